// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check a property on each rising clock edge outside reset
`define ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);
// check a property on each rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, ck, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

// ----- hdl/hbpc_pkg.sv -----
// Shared types and constants of the HLS to BGR converter
`timescale 1ns / 1ps
package hbpc_pkg;

	localparam logic [9:0]  HALF_CIRCLE = 10'd180;
	localparam logic [9:0]  HUE_SHIFT   = 10'd60;
	localparam logic [7:0]  SEGMENT     = 8'd30;
	localparam logic [7:0]  PLATEAU_END = 8'd90;
	localparam logic [7:0]  FALL_END    = 8'd120;
	localparam logic [7:0]  MID_LEVEL   = 8'd128;
	localparam logic [7:0]  FULL_LEVEL  = 8'd255;
	localparam logic [15:0] RECIP_30    = 16'd34953;
	localparam int          RECIP_SHIFT = 20;

	typedef enum logic [1:0] {
		SHIFT_UP,
		SHIFT_NONE,
		SHIFT_DOWN
	} shift_t;

	typedef enum logic [1:0] {
		REG_RISE,
		REG_HIGH,
		REG_FALL,
		REG_LOW
	} region_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} ctl_t;

endpackage

// ----- hdl/hbpc_chan.sv -----
// One color channel: hue wrap, ramp segment select, span scaling and output mux
`timescale 1ns / 1ps
module hbpc_chan (
	input  logic                 clk,
	input  hbpc_pkg::ctl_t       ctl,
	input  hbpc_pkg::shift_t     shift,
	input  logic [7:0]           hue,
	input  logic [7:0]           span_s2,
	input  logic [7:0]           lo_s3,
	input  logic [7:0]           hi_s3,
	input  logic [7:0]           l_s3,
	input  logic                 gray_s3,
	output logic [7:0]           value_s4
);

	logic signed [9:0]  shifted;
	logic [9:0]         wrapped10;
	logic [7:0]         wrapped;
	logic [7:0]         fall_t;
	logic [4:0]         t_next;
	hbpc_pkg::region_t  region_next;

	logic [4:0]         t_s1;
	hbpc_pkg::region_t  region_s1;
	logic [4:0]         t_s2;
	hbpc_pkg::region_t  region_s2;
	logic [12:0]        prod_s3;
	hbpc_pkg::region_t  region_s3;

	logic [28:0]        recip;
	logic [7:0]         quot;
	logic [7:0]         value_next;

	always_comb begin
		unique case (shift)
			hbpc_pkg::SHIFT_UP:   shifted = $signed({2'b00, hue}) + $signed(hbpc_pkg::HUE_SHIFT);
			hbpc_pkg::SHIFT_DOWN: shifted = $signed({2'b00, hue}) - $signed(hbpc_pkg::HUE_SHIFT);
			default:              shifted = $signed({2'b00, hue});
		endcase
		if (shifted >= $signed(hbpc_pkg::HALF_CIRCLE)) begin
			wrapped10 = 10'(shifted - $signed(hbpc_pkg::HALF_CIRCLE));
		end else if (shifted < 10'sd0) begin
			wrapped10 = 10'(shifted + $signed(hbpc_pkg::HALF_CIRCLE));
		end else begin
			wrapped10 = 10'(shifted);
		end
		wrapped = wrapped10[7:0];
		fall_t  = hbpc_pkg::FALL_END - wrapped;
		priority if (wrapped <= hbpc_pkg::SEGMENT) begin
			region_next = hbpc_pkg::REG_RISE;
			t_next      = wrapped[4:0];
		end else if (wrapped <= hbpc_pkg::PLATEAU_END) begin
			region_next = hbpc_pkg::REG_HIGH;
			t_next      = 5'd0;
		end else if (wrapped <= hbpc_pkg::FALL_END) begin
			region_next = hbpc_pkg::REG_FALL;
			t_next      = fall_t[4:0];
		end else begin
			region_next = hbpc_pkg::REG_LOW;
			t_next      = 5'd0;
		end
	end

	always_comb begin
		recip = 29'(prod_s3) * 29'(hbpc_pkg::RECIP_30);
		quot  = recip[hbpc_pkg::RECIP_SHIFT +: 8];
		if (gray_s3) begin
			value_next = l_s3;
		end else begin
			unique case (region_s3)
				hbpc_pkg::REG_RISE,
				hbpc_pkg::REG_FALL: value_next = lo_s3 + quot;
				hbpc_pkg::REG_HIGH: value_next = hi_s3;
				default:            value_next = lo_s3;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			t_s1      <= t_next;
			region_s1 <= region_next;
		end
		if (ctl.en_s2) begin
			t_s2      <= t_s1;
			region_s2 <= region_s1;
		end
		if (ctl.en_s3) begin
			prod_s3   <= 13'(span_s2) * 13'(t_s2);
			region_s3 <= region_s2;
		end
		if (ctl.en_s4) begin
			value_s4  <= value_next;
		end
	end

endmodule

// ----- hdl/hls_to_bgr_pixel_converter.sv -----
// HLS to BGR pixel converter: four-stage pipeline top level
// bgr_valid rises once an accepted request has passed the four register stages s1 to s4.
// One pixel per cycle while bgr_stall is low; a stage advances if empty or the next advances.
// Stall on bgr_stall backs up through the stages; hls_stall rises only when all four are full.
// Reset (arst_n low, asynchronous) clears the stage valid bits; data registers keep no reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hls_to_bgr_pixel_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hls_valid,
	output logic       hls_stall,
	input  logic [7:0] hue,
	input  logic [7:0] lightness,
	input  logic [7:0] saturation,
	output logic       bgr_valid,
	input  logic       bgr_stall,
	output logic [7:0] blue,
	output logic [7:0] green,
	output logic [7:0] red
);

	hbpc_pkg::ctl_t ctl;
	logic           v_s1, v_s2, v_s3, v_s4;

	logic        low_half;
	logic [8:0]  factor;
	logic [16:0] mul;
	logic [15:0] addend;
	logic [16:0] num_next;

	logic [15:0] num_s1;
	logic [7:0]  l_s1;
	logic        gray_s1;

	logic [16:0] div_sum;
	logic [8:0]  upper;
	logic [8:0]  lower;
	logic [7:0]  hi_next;
	logic [7:0]  lo_sat;
	logic [7:0]  lo_next;

	logic [7:0]  hi_s2, lo_s2, span_s2, l_s2;
	logic        gray_s2;
	logic [7:0]  hi_s3, lo_s3, l_s3;
	logic        gray_s3;

	assign ctl.en_s4 = !v_s4 || !bgr_stall;
	assign ctl.en_s3 = !v_s3 || ctl.en_s4;
	assign ctl.en_s2 = !v_s2 || ctl.en_s3;
	assign ctl.en_s1 = !v_s1 || ctl.en_s2;
	assign hls_stall = !ctl.en_s1;
	assign bgr_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1) v_s1 <= hls_valid;
			if (ctl.en_s2) v_s2 <= v_s1;
			if (ctl.en_s3) v_s3 <= v_s2;
			if (ctl.en_s4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		low_half = lightness <= hbpc_pkg::MID_LEVEL;
		if (low_half) begin
			factor = {1'b0, hbpc_pkg::FULL_LEVEL} + {1'b0, saturation};
			addend = 16'd0;
		end else begin
			factor = {1'b0, hbpc_pkg::FULL_LEVEL - saturation};
			addend = {saturation, 8'd0} - {8'd0, saturation};
		end
		mul      = 17'(lightness) * 17'(factor);
		num_next = mul + {1'b0, addend};
	end

	always_comb begin
		div_sum = {1'b0, num_s1} + 17'd1 + {9'd0, num_s1[15:8]};
		upper   = div_sum[16:8];
		lower   = {l_s1, 1'b0} - upper;
		hi_next = upper[8] ? hbpc_pkg::FULL_LEVEL : upper[7:0];
		lo_sat  = lower[8] ? hbpc_pkg::FULL_LEVEL : lower[7:0];
		lo_next = (lo_sat > hi_next) ? hi_next : lo_sat;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			num_s1  <= num_next[15:0];
			l_s1    <= lightness;
			gray_s1 <= saturation == 8'd0;
		end
		if (ctl.en_s2) begin
			hi_s2   <= hi_next;
			lo_s2   <= lo_next;
			span_s2 <= hi_next - lo_next;
			l_s2    <= l_s1;
			gray_s2 <= gray_s1;
		end
		if (ctl.en_s3) begin
			hi_s3   <= hi_s2;
			lo_s3   <= lo_s2;
			l_s3    <= l_s2;
			gray_s3 <= gray_s2;
		end
	end

	hbpc_chan u_red (
		.clk      (clk),
		.ctl      (ctl),
		.shift    (hbpc_pkg::SHIFT_UP),
		.hue      (hue),
		.span_s2  (span_s2),
		.lo_s3    (lo_s3),
		.hi_s3    (hi_s3),
		.l_s3     (l_s3),
		.gray_s3  (gray_s3),
		.value_s4 (red)
	);

	hbpc_chan u_green (
		.clk      (clk),
		.ctl      (ctl),
		.shift    (hbpc_pkg::SHIFT_NONE),
		.hue      (hue),
		.span_s2  (span_s2),
		.lo_s3    (lo_s3),
		.hi_s3    (hi_s3),
		.l_s3     (l_s3),
		.gray_s3  (gray_s3),
		.value_s4 (green)
	);

	hbpc_chan u_blue (
		.clk      (clk),
		.ctl      (ctl),
		.shift    (hbpc_pkg::SHIFT_DOWN),
		.hue      (hue),
		.span_s2  (span_s2),
		.lo_s3    (lo_s3),
		.hi_s3    (hi_s3),
		.l_s3     (l_s3),
		.gray_s3  (gray_s3),
		.value_s4 (blue)
	);

	`ASSERT_CLK(a_stall_full, clk, arst_n, hls_stall |-> (&{v_s1, v_s2, v_s3, v_s4} && bgr_stall), "stall with room")
	`ASSERT_CLK(a_levels, clk, arst_n, v_s2 |-> (lo_s2 <= hi_s2 && span_s2 == 8'(hi_s2 - lo_s2)), "bad levels")
	`ASSERT_CLK(a_advance, clk, arst_n, (v_s1 && ctl.en_s2) |=> v_s2, "request lost in stage two")
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !bgr_valid, "output valid after reset")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the HLS to BGR pixel converter
`timescale 1ns / 1ps
module testbench;

	localparam int HUE_PERIOD   = hbpc_pkg::HALF_CIRCLE;
	localparam int HUE_OFFSET   = hbpc_pkg::HUE_SHIFT;
	localparam int RAMP_SPAN    = hbpc_pkg::SEGMENT;
	localparam int PLATEAU_TOP  = hbpc_pkg::PLATEAU_END;
	localparam int FALL_TOP     = hbpc_pkg::FALL_END;
	localparam int LIGHT_MID    = hbpc_pkg::MID_LEVEL;
	localparam int LEVEL_MAX    = hbpc_pkg::FULL_LEVEL;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 60;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] lightness;
		logic [7:0] saturation;
	} hls_req_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} bgr_pixel_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       hls_valid = 1'b0;
	logic       hls_stall;
	logic [7:0] hue = '0;
	logic [7:0] lightness = '0;
	logic [7:0] saturation = '0;
	logic       bgr_valid;
	logic       bgr_stall = 1'b0;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;

	hls_req_t   pending_pixels[$];
	bgr_pixel_t expected_bgr[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic long_hold_req = 1'b0;
	int hold_left = 0;

	int accepted_count = 0;
	int checked_count = 0;
	int gray_count = 0;
	int wrapped_hue_count = 0;
	int input_stall_cycles = 0;
	int error_count = 0;

	hls_to_bgr_pixel_converter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hls_valid (hls_valid),
		.hls_stall (hls_stall),
		.hue       (hue),
		.lightness (lightness),
		.saturation(saturation),
		.bgr_valid (bgr_valid),
		.bgr_stall (bgr_stall),
		.blue      (blue),
		.green     (green),
		.red       (red)
	);

	function automatic int wrap_hue_angle(int h);
		if (h >= HUE_PERIOD)
			return h - HUE_PERIOD;
		if (h < 0)
			return h + HUE_PERIOD;
		return h;
	endfunction

	function automatic logic [7:0] ramp_channel(int lo, int hi, int h);
		int top;
		int bottom;
		top = (hi > LEVEL_MAX) ? LEVEL_MAX : hi;
		bottom = (lo > LEVEL_MAX) ? LEVEL_MAX : lo;
		if (bottom > top)
			bottom = top;
		if (h <= RAMP_SPAN)
			return 8'(bottom + (top - bottom) * h / RAMP_SPAN);
		if (h <= PLATEAU_TOP)
			return 8'(top);
		if (h <= FALL_TOP)
			return 8'(bottom + (top - bottom) * (FALL_TOP - h) / RAMP_SPAN);
		return 8'(bottom);
	endfunction

	function automatic bgr_pixel_t predict_bgr(hls_req_t px);
		int h;
		int l;
		int s;
		int upper;
		int lower;
		bgr_pixel_t res;
		h = px.hue;
		l = px.lightness;
		s = px.saturation;
		if (l <= LIGHT_MID)
			upper = l * (LEVEL_MAX + s) / LEVEL_MAX;
		else
			upper = (l * (LEVEL_MAX - s) + LEVEL_MAX * s) / LEVEL_MAX;
		lower = (2 * l >= upper) ? 2 * l - upper : 0;
		if (s == 0) begin
			res.blue = px.lightness;
			res.green = px.lightness;
			res.red = px.lightness;
		end else begin
			res.red = ramp_channel(lower, upper, wrap_hue_angle(h + HUE_OFFSET));
			res.green = ramp_channel(lower, upper, wrap_hue_angle(h));
			res.blue = ramp_channel(lower, upper, wrap_hue_angle(h - HUE_OFFSET));
		end
		return res;
	endfunction

	task automatic queue_pixel(int h, int l, int s);
		hls_req_t px;
		px.hue = 8'(h);
		px.lightness = 8'(l);
		px.saturation = 8'(s);
		pending_pixels.push_back(px);
	endtask

	task automatic queue_random_pixels(int count);
		int h;
		int l;
		int s;
		for (int i = 0; i < count; i++) begin
			h = ($urandom_range(9) < 7) ? $urandom_range(HUE_PERIOD - 1) : $urandom_range(255);
			l = ($urandom_range(7) == 0) ? $urandom_range(LIGHT_MID + 2, LIGHT_MID - 2)
				: $urandom_range(255);
			case ($urandom_range(9))
				0: s = 0;
				1: s = LEVEL_MAX;
				default: s = $urandom_range(255);
			endcase
			queue_pixel(h, l, s);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || hls_valid || expected_bgr.size() != 0);
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : drive_requests
		hls_req_t px;
		if (!arst_n) begin
			hls_valid <= 1'b0;
		end else begin
			if (hls_valid && hls_stall)
				input_stall_cycles++;
			if (hls_valid && !hls_stall) begin
				px.hue = hue;
				px.lightness = lightness;
				px.saturation = saturation;
				expected_bgr.push_back(predict_bgr(px));
				accepted_count++;
				if (saturation == 0)
					gray_count++;
				if (hue >= HUE_PERIOD)
					wrapped_hue_count++;
			end
			if (!hls_valid || !hls_stall) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					px = pending_pixels.pop_front();
					hls_valid <= 1'b1;
					hue <= px.hue;
					lightness <= px.lightness;
					saturation <= px.saturation;
				end else begin
					hls_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bgr_stall <= 1'b0;
			hold_left <= 0;
		end else if (long_hold_req) begin
			hold_left <= HOLD_CYCLES;
			bgr_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			bgr_stall <= 1'b1;
		end else begin
			bgr_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		bgr_pixel_t want;
		if (arst_n && bgr_valid && !bgr_stall) begin
			if (expected_bgr.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected pixel b=%0d g=%0d r=%0d", blue, green, red);
			end else begin
				want = expected_bgr.pop_front();
				checked_count++;
				if (blue !== want.blue || green !== want.green || red !== want.red) begin
					error_count++;
					if (error_count <= 10)
						$display("pixel %0d: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
							checked_count, want.blue, want.green, want.red, blue, green, red);
				end
			end
		end
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 14;
		recv_idle_pct = 51;
		queue_pixel(0, 0, 0);
		queue_pixel(255, 255, 255);
		queue_pixel(0, 128, 255);
		queue_pixel(60, 128, 255);
		queue_pixel(179, 128, 255);
		queue_pixel(0, 129, 255);
		queue_pixel(90, 255, 1);
		queue_pixel(0, 255, 0);
		queue_pixel(100, 77, 0);
		queue_pixel(30, 100, 200);
		queue_pixel(31, 100, 200);
		queue_pixel(60, 100, 200);
		queue_pixel(90, 100, 200);
		queue_pixel(91, 100, 200);
		queue_pixel(120, 100, 200);
		queue_pixel(121, 100, 200);
		queue_pixel(150, 100, 200);
		queue_pixel(179, 100, 200);
		queue_pixel(180, 100, 200);
		queue_pixel(200, 100, 200);
		queue_pixel(239, 100, 200);
		queue_pixel(240, 100, 200);
		queue_pixel(255, 100, 200);
		queue_pixel(45, 129, 128);
		queue_pixel(15, 1, 1);
		queue_random_pixels(630);
		wait_drained();

		send_idle_pct = 51;
		recv_idle_pct = 14;
		queue_random_pixels(650);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_pixels(120);
		@(negedge clk);
		long_hold_req = 1'b1;
		@(negedge clk);
		long_hold_req = 1'b0;
		queue_random_pixels(530);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("converted %0d pixels (%0d gray, %0d with hue above 179), %0d checked",
			accepted_count, gray_count, wrapped_hue_count, checked_count);
		$display("input held back for %0d cycles, %0d mismatches",
			input_stall_cycles, error_count);
		if (error_count == 0 && expected_bgr.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
